/* sv/tms_pkg.sv */
// tms_pkg: shared types and constants of the transform matrix stack
// depends on nothing
package tms_pkg;
  localparam int unsigned ELEM_W = 64;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic       REQ_PUSH = 1'b0;
  localparam logic       REQ_POP  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic              keep_depth;
    logic [1:0]        row_index;
    logic signed [63:0] elem_0;
    logic signed [63:0] elem_1;
    logic signed [63:0] elem_2;
    logic signed [63:0] elem_3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [63:0] res_0;
    logic signed [63:0] res_1;
    logic signed [63:0] res_2;
    logic signed [63:0] res_3;
    logic [4:0]         stack_depth;
    logic [1:0]         status;
    logic               last;
  } out_word_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat_add = s;
  endfunction
endpackage

/* sv/tms_ram.sv */
// tms_ram: generic single port write, single port registered read memory
// depends on nothing
module tms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/tms_lane.sv */
// tms_lane: one multiply lane, q31.32 product with floor shift and saturation
// depends on tms_pkg; 64x64 cut into four 32x32 partial products over stages
module tms_lane (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import tms_pkg::*;
  logic        neg_r, neg2_r;
  logic [31:0] a0_r, a1_r, b0_r, b1_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [63:0] ma, mb;
  logic [127:0] mag, sgn;
  logic [63:0] r;
  logic [63:0] p_nxt;
  logic [63:0] p_r;
  assign ma = a[63] ? 64'd0 - a : a;
  assign mb = b[63] ? 64'd0 - b : b;
  assign p  = p_r;
  always_ff @(posedge clk) begin
    neg_r <= a[63] ^ b[63];
    a0_r <= ma[31:0]; a1_r <= ma[63:32];
    b0_r <= mb[31:0]; b1_r <= mb[63:32];
    neg2_r <= neg_r;
    p00_r <= a0_r * b0_r; p01_r <= a0_r * b1_r;
    p10_r <= a1_r * b0_r; p11_r <= a1_r * b1_r;
    p_r <= p_nxt;
  end
  always_comb begin
    mag = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
        + {p11_r, 64'd0};
    sgn = neg2_r ? 128'd0 - mag : mag;
    r = sgn[95:32];
    if (sgn[127:96] != {32{r[63]}})
      p_nxt = sgn[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      p_nxt = r;
  end
endmodule

/* sv/transform_matrix_stack_core.sv */
// transform_matrix_stack_core: top level of the 4x4 transform matrix stack
// depends on tms_pkg, tms_lane, tms_ram
//
// usage: an input word is taken when start is high and busy is low. a push
// matrix arrives as four row words; a pop is one word. rows 0..2 give no
// result. row 3 of a push gives four result words (rows 0..3, last on the
// fourth); an overflowed push or a pop gives one word with last set.
// each result word is on out_ for one cycle with out_valid high; the receiver
// cannot stall, so results leave as soon as they are made.
// busy: a push row at depth above zero keeps busy high through four column
// reads of the stored matrix below (one ram port) each feeding four multiply
// lanes, then the ram read and 3-stage lane pipeline drain. a row at depth
// zero, a rejected row or a pop makes no ram reads.
// order: row 3 emits its four words after the drain; the 16-word store write
// runs beside the emit and busy stays high until it ends. a pop answers from
// S_ONE; a rejected row 3 passes through S_DRAIN and then S_ONE.
// reset clears depth, the accumulator and the reject flag; the store is not
// cleared, a slot is always written before it is read.
module transform_matrix_stack_core #(
  parameter int unsigned STACK_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tms_pkg::in_word_t  in_word,
  output logic               out_valid,
  output tms_pkg::out_word_t out_word
);
  import tms_pkg::*;
  localparam int unsigned AW = $clog2(STACK_SLOTS * 16);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DRAIN = 3'd2,
                         S_EMIT = 3'd3, S_ONE = 3'd4;
  localparam logic [4:0] TOP = 5'(STACK_SLOTS - 1);

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  depth_r;
  logic        rej_r;
  logic [63:0] acc_r [16];
  in_word_t    item_r;
  logic [2:0]  cnt_r;        // issue / drain counter over rows i
  logic [1:0]  ri_r [4];     // row tag through ram + lane latency
  logic        vld_r [4];
  logic [1:0]  emit_r;
  out_word_t   out_r;
  logic        out_valid_r;

  // store: ram port reads stack[d-1][i][k], port write copies the result
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] rdata, wdata;
  logic        wact_r;
  logic [3:0]  widx_r;

  tms_ram #(.WIDTH(64), .DEPTH(STACK_SLOTS * 16)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  logic [63:0] bel [4];
  logic [63:0] prod [4];
  assign bel[0] = item_r.elem_0; assign bel[1] = item_r.elem_1;
  assign bel[2] = item_r.elem_2; assign bel[3] = item_r.elem_3;

  // four lanes, one per column j
  for (genvar j = 0; j < 4; j++) begin : g_lane
    tms_lane u_lane (.clk(clk), .a(rdata), .b(bel[j]), .p(prod[j]));
  end

  logic [AW-1:0] below_base;
  assign below_base = AW'((32'(depth_r) - 32'd1) * 16);
  assign raddr = below_base + AW'({cnt_r[1:0], item_r.row_index});
  assign we    = wact_r;
  assign waddr = AW'(32'(depth_r) * 16) + AW'(widx_r);
  assign wdata = acc_r[widx_r];

  assign busy = (state_r != S_IDLE) || wact_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  logic over;
  assign over = (depth_r != 5'd0) && (depth_r >= TOP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start && !busy) begin
        if (in_word.req_type == REQ_POP) state_nxt = S_ONE;
        else if (over || (in_word.row_index != 2'd0 && rej_r) || depth_r == 5'd0)
          state_nxt = S_DRAIN;
        else state_nxt = S_MUL;
      end
      S_MUL:   if (cnt_r == 3'd3) state_nxt = S_DRAIN;
      S_DRAIN: if (!vld_r[0] && !vld_r[1] && !vld_r[2] && !vld_r[3] && cnt_r == 3'd0) begin
        if (item_r.row_index != 2'd3) state_nxt = S_IDLE;
        else if (rej_r) state_nxt = S_ONE;
        else state_nxt = S_EMIT;
      end
      S_EMIT:  if (emit_r == 2'd3) state_nxt = S_IDLE;
      S_ONE:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; depth_r <= 5'd0; rej_r <= 1'b0; cnt_r <= 3'd0;
      out_valid_r <= 1'b0; emit_r <= 2'd0; wact_r <= 1'b0; widx_r <= 4'd0;
      for (int n = 0; n < 16; n++) acc_r[n] <= 64'd0;
      for (int n = 0; n < 4; n++) vld_r[n] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_EMIT) || (state_r == S_ONE);
      // pipeline tag: follows the ram read register and the lane pipeline
      vld_r[0] <= (state_r == S_MUL);
      ri_r[0]  <= cnt_r[1:0];
      vld_r[1] <= vld_r[0]; ri_r[1] <= ri_r[0];
      vld_r[2] <= vld_r[1]; ri_r[2] <= ri_r[1];
      vld_r[3] <= vld_r[2]; ri_r[3] <= ri_r[2];
      if (vld_r[3])
        for (int j = 0; j < 4; j++)
          acc_r[{ri_r[3], 2'(j)}] <= sat_add(acc_r[{ri_r[3], 2'(j)}], prod[j]);
      // depth rises only once the whole slot is written
      if (wact_r) begin
        widx_r <= widx_r + 4'd1;
        if (widx_r == 4'd15) begin
          wact_r <= 1'b0;
          if (!item_r.keep_depth) depth_r <= depth_r + 5'd1;
        end
      end
      unique case (state_r)
        S_IDLE: if (start && !busy) begin
          item_r <= in_word; cnt_r <= 3'd0;
          if (in_word.req_type == REQ_PUSH) begin
            if (in_word.row_index == 2'd0) begin
              // a copy-in fills row 0 itself
              for (int n = 0; n < 16; n++)
                if (depth_r != 5'd0 || n >= 4) acc_r[n] <= 64'd0;
              rej_r <= over;
            end else if (over) rej_r <= 1'b1;
            if (depth_r == 5'd0 && !(in_word.row_index != 2'd0 && rej_r)) begin
              acc_r[{in_word.row_index, 2'd0}] <= in_word.elem_0;
              acc_r[{in_word.row_index, 2'd1}] <= in_word.elem_1;
              acc_r[{in_word.row_index, 2'd2}] <= in_word.elem_2;
              acc_r[{in_word.row_index, 2'd3}] <= in_word.elem_3;
            end
          end
        end
        S_MUL: cnt_r <= (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
        S_DRAIN: if (state_nxt == S_EMIT) begin
          emit_r <= 2'd0; wact_r <= 1'b1; widx_r <= 4'd0;
        end
        S_EMIT: begin
          out_r.out_row <= emit_r;
          out_r.res_0 <= acc_r[{emit_r, 2'd0}]; out_r.res_1 <= acc_r[{emit_r, 2'd1}];
          out_r.res_2 <= acc_r[{emit_r, 2'd2}]; out_r.res_3 <= acc_r[{emit_r, 2'd3}];
          out_r.status <= ST_OK;
          out_r.last <= (emit_r == 2'd3);
          out_r.stack_depth <= (item_r.keep_depth) ? depth_r : depth_r + 5'd1;
          emit_r <= emit_r + 2'd1;
        end
        S_ONE: begin
          out_r.out_row <= 2'd0;
          out_r.res_0 <= 64'd0; out_r.res_1 <= 64'd0;
          out_r.res_2 <= 64'd0; out_r.res_3 <= 64'd0;
          out_r.last <= 1'b1;
          if (item_r.req_type == REQ_POP) begin
            out_r.status <= (depth_r == 5'd0) ? ST_UNDERFLOW : ST_OK;
            out_r.stack_depth <= (depth_r == 5'd0) ? 5'd0 : depth_r - 5'd1;
            if (depth_r != 5'd0) depth_r <= depth_r - 5'd1;
          end else begin
            out_r.status <= ST_OVERFLOW;
            out_r.stack_depth <= depth_r;
          end
        end
        default: ;
      endcase
    end
  end

  // the store write uses the pre-increment depth: depth must hold while writing
  assert property (@(posedge clk) disable iff (!rst_n)
    wact_r && $past(wact_r) |-> $stable(depth_r))
    else $error("depth changed during store write");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> !vld_r[3])
    else $error("emit while accumulating");
  assert property (@(posedge clk) disable iff (!rst_n) depth_r <= TOP)
    else $error("depth beyond stack");
endmodule

/* sim/transform_matrix_stack_checker.sv */
// transform_matrix_stack_checker: predicts and checks result words of the matrix stack
// depends on tms_pkg; watches the start/busy and out_valid channels of the core
module transform_matrix_stack_checker #(
  parameter int unsigned STACK_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tms_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  tms_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  import tms_pkg::*;

  logic [63:0] slots [STACK_SLOTS][16];
  logic [63:0] acc [16];
  logic [4:0]  depth;
  logic        rejected;
  out_word_t   expected_words [$];

  assign pending = expected_words.size();

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  // full 128-bit product, floor shift by 32, clamp to 64 bits
  function automatic logic [63:0] q_product(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] p;
    logic signed [127:0] sh;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    sh = p >>> 32;
    if (sh > 128'sh7FFFFFFFFFFFFFFF) return {1'b0, {63{1'b1}}};
    if (sh < -128'sh8000000000000000) return {1'b1, 63'd0};
    return sh[63:0];
  endfunction

  function automatic out_word_t status_word(logic [1:0] st);
    out_word_t w;
    w = '0;
    w.stack_depth = depth;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic predict_word(in_word_t w);
    logic [63:0] e [4];
    logic [63:0] a;
    out_word_t   r;
    int          k;
    e = '{w.elem_0, w.elem_1, w.elem_2, w.elem_3};
    k = w.row_index;
    if (w.req_type == REQ_POP) begin
      if (depth == 0) begin
        expected_words.push_back(status_word(ST_UNDERFLOW));
      end else begin
        depth = depth - 5'd1;
        expected_words.push_back(status_word(ST_OK));
      end
      return;
    end
    if (k == 0) begin
      foreach (acc[i]) acc[i] = '0;
      rejected = 1'b0;
    end
    if (depth > 0 && depth >= STACK_SLOTS - 1) rejected = 1'b1;
    if (!rejected) begin
      if (depth == 0) begin
        for (int j = 0; j < 4; j++) acc[k*4+j] = e[j];
      end else begin
        for (int i = 0; i < 4; i++) begin
          a = slots[depth-1][i*4+k];
          for (int j = 0; j < 4; j++)
            acc[i*4+j] = add_clamped(acc[i*4+j], q_product(a, e[j]));
        end
      end
    end
    if (k != 3) return;
    if (rejected) begin
      expected_words.push_back(status_word(ST_OVERFLOW));
      return;
    end
    for (int i = 0; i < 16; i++) slots[depth][i] = acc[i];
    if (!w.keep_depth) depth = depth + 5'd1;
    for (int i = 0; i < 4; i++) begin
      r = '0;
      r.out_row = 2'(i);
      r.res_0 = acc[i*4];
      r.res_1 = acc[i*4+1];
      r.res_2 = acc[i*4+2];
      r.res_3 = acc[i*4+3];
      r.stack_depth = depth;
      r.status = ST_OK;
      r.last = (i == 3);
      expected_words.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    depth = '0;
    rejected = 1'b0;
    foreach (acc[i]) acc[i] = '0;
  end

  always @(posedge clk) begin
    out_word_t x;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          x = expected_words.pop_front();
          check_field("out_row", 64'(x.out_row), 64'(out_word.out_row));
          check_field("res_0", x.res_0, out_word.res_0);
          check_field("res_1", x.res_1, out_word.res_1);
          check_field("res_2", x.res_2, out_word.res_2);
          check_field("res_3", x.res_3, out_word.res_3);
          check_field("stack_depth", 64'(x.stack_depth), 64'(out_word.stack_depth));
          check_field("status", 64'(x.status), 64'(out_word.status));
          check_field("last", 64'(x.last), 64'(out_word.last));
        end
      end
      if (start && !busy) predict_word(in_word);
    end
  end
endmodule

/* sim/transform_matrix_stack_core_tb.sv */
// transform_matrix_stack_core_tb: stimulus and verdict for the matrix stack core
// depends on tms_pkg, transform_matrix_stack_core and transform_matrix_stack_checker
module transform_matrix_stack_core_tb;
  import tms_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  bit        gaps_on = 1'b1;

  always #5 clk = ~clk;

  transform_matrix_stack_core #(.STACK_SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  transform_matrix_stack_checker #(.STACK_SLOTS(SLOTS)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mix of extremes, small fractions and full random bit patterns
  function automatic logic [63:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return {1'b0, {63{1'b1}}};
      1: return {1'b1, 63'd0};
      2: return {$urandom, $urandom};
      3: return {{32{1'b0}}, 32'd0} + 64'h1_0000_0000;
      4: return $signed({{32{1'b1}}, $urandom}) >>> $urandom_range(0, 8);
      default: return $signed({{33{$urandom_range(0, 1) == 1}}, 31'($urandom)});
    endcase
  endfunction

  // hands one word over: optional idle gap, then hold start until accepted;
  // start stays high until the next word or the end of the run replaces it
  task automatic send_word(logic req, logic keep, logic [1:0] row,
                           logic [63:0] e0, logic [63:0] e1,
                           logic [63:0] e2, logic [63:0] e3);
    while (gaps_on && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      in_word <= {$urandom_range(0, 1) == 1, 1'b0, 2'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
      @(negedge clk);
    end
    start <= 1'b1;
    in_word <= '{req, keep, row, e0, e1, e2, e3};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_matrix(logic keep, bit scramble);
    logic [1:0] row;
    for (int r = 0; r < 4; r++) begin
      row = 2'(r);
      // broken sequence: rows 0..2 are replaced by random rows from 0..2, repeats allowed, row 3 last
      if (scramble && r < 3) row = 2'($urandom_range(0, 2));
      send_word(REQ_PUSH, r == 3 ? keep : 1'($urandom), row,
                pick_elem(), pick_elem(), pick_elem(), pick_elem());
      // a pop wedged into a push; the checker predicts it like any other word
      if (scramble && r == 1 && $urandom_range(0, 3) == 0)
        send_word(REQ_POP, 1'b0, 2'd0, '0, '0, '0, '0);
    end
  endtask

  task automatic push_identity_scaled(logic [63:0] v, logic keep);
    for (int r = 0; r < 4; r++)
      send_word(REQ_PUSH, keep, 2'(r), r == 0 ? v : 64'd0, r == 1 ? v : 64'd0,
                r == 2 ? v : 64'd0, r == 3 ? v : 64'd0);
  endtask

  initial begin
    int items;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: pop on empty, extreme copy-in, saturating multiply
    send_word(REQ_POP, 1'b0, 2'd0, '0, '0, '0, '0);
    push_identity_scaled({1'b0, {63{1'b1}}}, 1'b0);
    push_identity_scaled({1'b1, 63'd0}, 1'b0);
    push_identity_scaled(64'h0000_0000_8000_0001, 1'b1);
    send_word(REQ_POP, 1'b0, 2'd0, '0, '0, '0, '0);
    send_word(REQ_POP, 1'b0, 2'd0, '0, '0, '0, '0);
    send_word(REQ_POP, 1'b0, 2'd0, '0, '0, '0, '0);
    items = 16;

    // random: mostly well-formed pushes, climbing to overflow and back
    while (items < 310) begin
      gaps_on = !(items > 120 && items < 180);
      case ($urandom_range(0, 9))
        0, 1: begin
          send_word(REQ_POP, 1'($urandom), 2'($urandom), pick_elem(), '0, '0, '0);
          items++;
        end
        2: begin
          push_matrix(1'($urandom), 1'b1);
          items += 4;
        end
        default: begin
          push_matrix($urandom_range(0, 5) == 0, 1'b0);
          items += 4;
        end
      endcase
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
